// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros shared by the sliding window maximum RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, disabled while reset is held.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication, disabled while reset is held.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_SAME(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ----- rtl/core/swm_pkg.sv -----
// ----------------------------------------------------------------------------
// swm_pkg
// Types and constants of the sliding window maximum block.
// ----------------------------------------------------------------------------
package swm_pkg;

    localparam int DATA_W         = 32;
    localparam int WIN_W          = 7;
    localparam int WINDOW_MAX_DEF = 64;
    localparam logic [WIN_W-1:0] WIN_RESET = 7'd3;

    typedef logic signed [DATA_W-1:0] t_sample;
    typedef logic [WIN_W-1:0]         t_win_cfg;

    // Broadcast to every cell of the chain.
    typedef struct packed {
        logic    advance;   // a sample transaction is taken this cycle
        logic    has_prev;  // run already holds samples
        t_sample sample;
    } t_cell_ctl;

endpackage

// ----- rtl/core/swm_ifs.sv -----
// ----------------------------------------------------------------------------
// swm_ifs
// Valid/ready channels of the sliding window maximum block.
// ----------------------------------------------------------------------------
interface swm_in_if import swm_pkg::*; ();
    logic    valid;
    logic    ready;
    t_sample sample;
    logic    start_req;

    modport source (output valid, sample, start_req, input ready);
    modport sink   (input valid, sample, start_req, output ready);
endinterface

interface swm_out_if import swm_pkg::*; ();
    logic    valid;
    logic    ready;
    t_sample window_max;

    modport source (output valid, window_max, input ready);
    modport sink   (input valid, window_max, output ready);
endinterface

interface swm_cfg_if import swm_pkg::*; ();
    logic     valid;
    logic     ready;
    t_win_cfg window_size;

    modport source (output valid, window_size, input ready);
    modport sink   (input valid, window_size, output ready);
endinterface

// ----- rtl/core/sliding_window_maximum_core.sv -----
// ----------------------------------------------------------------------------
// sliding_window_maximum_core
// Throughput: one sample transaction per cycle unless a held result stalls;
//   every cell of the chain updates in the cycle that takes the sample.
// Result: loaded into the output register at the accepting edge; a full
//   window gives one result, a filling run none.
// Reset: synchronous, active low; empties the run, window size back to 3.
// ----------------------------------------------------------------------------
module sliding_window_maximum_core import swm_pkg::*; #(
    parameter int WINDOW_MAX = WINDOW_MAX_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    swm_cfg_if.sink   i_cfg,
    swm_in_if.sink    i_in,
    swm_out_if.source o_out
);

    `include "assert_macros.svh"

    // Fill count and effective window share one width: both reach WINDOW_MAX.
    localparam int WW = $clog2(WINDOW_MAX + 1);
    localparam int CW = (WW > WIN_W) ? WW : WIN_W;
    localparam logic [CW-1:0] WMAX_C = CW'(WINDOW_MAX);
    localparam logic [WW-1:0] WMAX_W = WW'(WINDOW_MAX);

    logic [WW-1:0] r_win;       // effective window, already clamped
    logic [WW-1:0] n_win;
    logic [WW-1:0] r_fill;      // samples in this run, saturating
    logic [WW-1:0] n_fill;
    logic [WW-1:0] w_fill_base;
    logic          r_out_valid;
    t_sample       r_out_max;
    logic          w_in_acc;
    logic          w_cfg_acc;
    logic          w_emit;
    t_cell_ctl     w_ctl;
    t_sample       w_win_max;

    // Window size clamp: zero acts as one, large values saturate.
    function automatic logic [WW-1:0] clamp_win(input t_win_cfg v);
        logic [CW-1:0] ext;
        logic [CW-1:0] res;
        begin
            ext = CW'(v);
            if (ext == '0) begin
                res = CW'(1);
            end else if (ext > WMAX_C) begin
                res = WMAX_C;
            end else begin
                res = ext;
            end
            return res[WW-1:0];
        end
    endfunction

    // Handshakes. The output register parts the two sides: a new sample is
    // taken when no result is held or the held result leaves in the same cycle.
    assign i_cfg.ready = 1'b1;
    assign w_cfg_acc   = i_cfg.valid && i_cfg.ready;
    assign i_in.ready  = !r_out_valid || o_out.ready;
    assign w_in_acc    = i_in.valid && i_in.ready;

    // A start transaction empties the run before its own sample goes in.
    assign w_fill_base = i_in.start_req ? '0 : r_fill;
    assign n_fill      = (w_fill_base < WMAX_W) ? (w_fill_base + WW'(1)) : w_fill_base;
    assign w_emit      = n_fill >= r_win;
    assign n_win       = clamp_win(i_cfg.window_size);

    assign w_ctl.advance  = w_in_acc;
    assign w_ctl.has_prev = (r_fill != '0) && !i_in.start_req;
    assign w_ctl.sample   = i_in.sample;

    // Cells hold running maxima by sample age; the tail value is the
    // maximum of the window after this sample.
    swm_chain #(
        .CELLS (WINDOW_MAX),
        .WW    (WW)
    ) u_chain (
        .i_clk     (i_clk),
        .i_ctl     (w_ctl),
        .i_win     (r_win),
        .o_win_max (w_win_max)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win       <= clamp_win(WIN_RESET);
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_cfg_acc) begin
                r_win <= n_win;
            end
            if (w_in_acc) begin
                r_fill      <= n_fill;
                r_out_valid <= w_emit;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc && w_emit) begin
            r_out_max <= w_win_max;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.window_max = r_out_max;

    // A new result only appears after a sample transaction.
    `ASSERT_SAME(a_result_from_sample, i_clk, i_rst_n, $rose(r_out_valid), $past(w_in_acc))
    // A start transaction leaves a run of exactly one sample.
    `ASSERT_NEXT(a_start_fill_one, i_clk, i_rst_n, w_in_acc && i_in.start_req, r_fill == WW'(1))
    // The window maximum is never below the newest sample.
    `ASSERT_NEXT(a_max_ge_sample, i_clk, i_rst_n, w_in_acc && w_emit, r_out_max >= $past(i_in.sample))
    // Effective window stays in its legal range.
    `ASSERT_SAME(a_win_range, i_clk, i_rst_n, 1'b1, (r_win != '0) && (r_win <= WMAX_W))

endmodule

// ----- rtl/core/swm_cell.sv -----
// ----------------------------------------------------------------------------
// swm_cell
// One cell: holds the maximum over the newest samples up to its position.
// ----------------------------------------------------------------------------
module swm_cell import swm_pkg::*; (
    input  logic      i_clk,
    input  t_cell_ctl i_ctl,
    input  logic      i_in_window,
    input  t_sample   i_prev,
    input  t_sample   i_tail,
    output t_sample   o_p
);

    t_sample r_p;
    t_sample n_p;

    always_comb begin
        if (!i_in_window) begin
            n_p = i_tail;
        end else if (i_ctl.has_prev && (i_prev > i_ctl.sample)) begin
            n_p = i_prev;
        end else begin
            n_p = i_ctl.sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.advance) begin
            r_p <= n_p;
        end
    end

    assign o_p = r_p;

endmodule

// ----- rtl/core/swm_chain.sv -----
// ----------------------------------------------------------------------------
// swm_chain
// Row of cells; cell j keeps the max of valid samples aged 0..j.
// ----------------------------------------------------------------------------
module swm_chain import swm_pkg::*; #(
    parameter int CELLS = WINDOW_MAX_DEF,
    parameter int WW    = $clog2(WINDOW_MAX_DEF + 1)
) (
    input  logic          i_clk,
    input  t_cell_ctl     i_ctl,
    input  logic [WW-1:0] i_win,
    output t_sample       o_win_max
);

    localparam int IW = (CELLS > 1) ? $clog2(CELLS) : 1;

    t_sample          w_p [CELLS];
    t_sample          w_tail;
    t_sample          w_sel;
    logic [WW-1:0]    w_idx_full;
    logic [IW-1:0]    w_idx;

    // Cell at age w-2 feeds the new window maximum.
    assign w_idx_full = i_win - WW'(2);
    assign w_idx      = w_idx_full[IW-1:0];
    assign w_sel      = w_p[w_idx];

    always_comb begin
        if ((i_win > WW'(1)) && i_ctl.has_prev && (w_sel > i_ctl.sample)) begin
            w_tail = w_sel;
        end else begin
            w_tail = i_ctl.sample;
        end
    end

    for (genvar j = 0; j < CELLS; j++) begin : g_cell
        localparam logic [WW-1:0] IDX = WW'(j);
        t_sample w_prev;
        logic    w_in_win;

        if (j == 0) begin : g_head
            assign w_prev = i_ctl.sample;
        end else begin : g_body
            assign w_prev = w_p[j-1];
        end

        assign w_in_win = IDX < i_win;

        swm_cell u_cell (
            .i_clk       (i_clk),
            .i_ctl       (i_ctl),
            .i_in_window (w_in_win),
            .i_prev      (w_prev),
            .i_tail      (w_tail),
            .o_p         (w_p[j])
        );
    end

    assign o_win_max = w_tail;

endmodule

// ----- tb/sv/sliding_window_maximum_core_tb.sv -----
// ----------------------------------------------------------------------------
// sliding_window_maximum_core_tb
// Self-checking bench for the sliding window maximum core. A model of the
// candidate queue follows every accepted sample and window write and queues
// the window maximum it expects. Each result transaction is checked against
// the oldest queued value. Directed cases come first, then random runs under
// three idle patterns.
// ----------------------------------------------------------------------------
module sliding_window_maximum_core_tb;
    import swm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS = WINDOW_MAX_DEF;
    localparam int RANDOM_PER_MODE = 350;   // three idle patterns, ~1050 samples
    localparam int SETTLE_CYCLES = 4;       // settle time after the expected results drain

    typedef logic [$clog2(2 * SLOTS)-1:0] t_tag;

    localparam t_sample S_MAX = 32'sh7FFF_FFFF;
    localparam t_sample S_MIN = 32'sh8000_0000;

    logic i_clk = 1'b0;
    logic i_rst_n;

    swm_cfg_if cfg_ch ();
    swm_in_if  smp_ch ();
    swm_out_if max_ch ();

    sliding_window_maximum_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_ch),
        .i_in    (smp_ch),
        .o_out   (max_ch)
    );

    always #5 i_clk = ~i_clk;

    // Idle rates in percent, changed between random phases.
    int unsigned src_idle_pct;
    int unsigned sink_idle_pct;
    int unsigned fail_count;

    // ------------------------------------------------------------------
    // Window model: monotonic queue of candidate maxima, front at index 0.
    // Tags are sample indexes modulo twice the deepest window, so the
    // age of a candidate is a plain wrapping subtraction.
    // ------------------------------------------------------------------
    t_win_cfg    win_reg;
    t_sample     peak_val [SLOTS];
    t_tag        peak_tag [SLOTS];
    int unsigned peak_cnt;
    t_tag        next_tag;
    int unsigned run_fill;

    t_sample     pending_max_q [$];

    function automatic int unsigned active_window();
        int unsigned w;
        w = win_reg;
        if (w == 0)
            w = 1;                  // zero behaves as a window of one
        if (w > SLOTS)
            w = SLOTS;              // oversize saturates at the deepest window
        return w;
    endfunction

    task automatic advance_window(input t_sample s, input logic st,
                                  output bit has_max, output t_sample max_now);
        int unsigned w;
        t_tag        age;
        w = active_window();
        if (st) begin
            peak_cnt = 0;
            run_fill = 0;
            next_tag = '0;
        end
        // Front candidates that fell out of the window leave first. After a
        // shrink several can go at once.
        while (peak_cnt > 0) begin
            age = next_tag - peak_tag[0];
            if (age < w)
                break;
            for (int k = 1; k < peak_cnt; k++) begin
                peak_val[k-1] = peak_val[k];
                peak_tag[k-1] = peak_tag[k];
            end
            peak_cnt--;
        end
        // Strictly smaller candidates can never win again; equal ones stay.
        while (peak_cnt > 0 && peak_val[peak_cnt-1] < s)
            peak_cnt--;
        if (peak_cnt < SLOTS) begin
            peak_val[peak_cnt] = s;
            peak_tag[peak_cnt] = next_tag;
            peak_cnt++;
        end else begin
            peak_val[SLOTS-1] = s;
            peak_tag[SLOTS-1] = next_tag;
        end
        if (run_fill < SLOTS)
            run_fill++;
        next_tag++;
        has_max = (run_fill >= w);
        max_now = peak_val[0];
    endtask

    task automatic report_error(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        fail_count++;
    endtask

    // ------------------------------------------------------------------
    // Monitor and scoreboard in one process, so that a sample taken and a
    // result leaving at the same edge are seen in a fixed order.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        bit      has_max;
        t_sample max_now;
        t_sample want;
        if (!i_rst_n) begin
            win_reg  = WIN_RESET;
            peak_cnt = 0;
            next_tag = '0;
            run_fill = 0;
            pending_max_q.delete();
        end else begin
            if (cfg_ch.valid && cfg_ch.ready)
                win_reg = cfg_ch.window_size;
            if (smp_ch.valid && smp_ch.ready) begin
                advance_window(smp_ch.sample, smp_ch.start_req, has_max, max_now);
                if (has_max)
                    pending_max_q.insert(pending_max_q.size(), max_now);
            end
            if (max_ch.valid && max_ch.ready) begin
                if (pending_max_q.size() == 0) begin
                    report_error($sformatf("unexpected result %0d", max_ch.window_max));
                end else begin
                    want = pending_max_q[0];
                    pending_max_q.delete(0);
                    if (max_ch.window_max !== want)
                        report_error($sformatf("window_max got %0d expected %0d",
                                               max_ch.window_max, want));
                end
            end
        end
    end

    // Result side back-pressure.
    always @(posedge i_clk) begin
        max_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
    end

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // Valid is left high on return so back-to-back samples need no gap;
    // callers drop it through wait_idle.
    task automatic send_sample(input t_sample s, input logic st);
        while ($urandom_range(99) < src_idle_pct) begin
            smp_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        smp_ch.valid     <= 1'b1;
        smp_ch.sample    <= s;
        smp_ch.start_req <= st;
        do @(posedge i_clk); while (!smp_ch.ready);
    endtask

    // Drop valid and let every expected result drain, plus SETTLE_CYCLES for
    // a sample still in flight that gives no result.
    task automatic wait_idle();
        smp_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_max_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Only called while the core is idle.
    task automatic set_window(input t_win_cfg w);
        cfg_ch.valid       <= 1'b1;
        cfg_ch.window_size <= w;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic set_idle_mode(input int mode);
        case (mode)
            0: begin
                src_idle_pct  = 23;
                sink_idle_pct = 80;
            end
            1: begin
                src_idle_pct  = 80;
                sink_idle_pct = 23;
            end
            default: begin
                src_idle_pct  = 0;
                sink_idle_pct = 0;
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset alone must leave an empty run with the default window of three.
    task automatic test_no_start_after_reset();
        send_sample(S_MAX, 1'b0);
        send_sample(S_MIN, 1'b0);
        send_sample(32'sd0, 1'b0);
        send_sample(-32'sd1, 1'b0);
        wait_idle();
    endtask

    // Full-scale values, equal neighbors and a restart in the middle.
    task automatic test_signed_extremes();
        set_window(7'd2);
        send_sample(S_MIN, 1'b1);
        send_sample(S_MIN, 1'b0);
        send_sample(S_MAX, 1'b0);
        send_sample(-32'sd1, 1'b0);
        send_sample(32'sd1, 1'b0);
        send_sample(32'sd0, 1'b0);
        send_sample(S_MAX, 1'b1);
        send_sample(S_MAX, 1'b0);
        wait_idle();
    endtask

    // A zero window acts as one: every sample is its own maximum.
    task automatic test_window_zero();
        set_window(7'd0);
        send_sample(32'sd5, 1'b1);
        send_sample(-32'sd5, 1'b0);
        send_sample(S_MIN, 1'b0);
        wait_idle();
    endtask

    // Descending run fills the queue, then the window shrinks and grows
    // without a restart.
    task automatic test_shrink_and_grow();
        set_window(7'd6);
        send_sample(32'sd100, 1'b1);
        send_sample(32'sd90, 1'b0);
        send_sample(32'sd80, 1'b0);
        send_sample(32'sd70, 1'b0);
        send_sample(32'sd60, 1'b0);
        send_sample(32'sd50, 1'b0);
        wait_idle();
        set_window(7'd2);
        send_sample(32'sd30, 1'b0);
        send_sample(32'sd45, 1'b0);
        wait_idle();
        set_window(7'd5);
        send_sample(32'sd20, 1'b0);
        send_sample(32'sd10, 1'b0);
        send_sample(32'sd55, 1'b0);
        wait_idle();
    endtask

    function automatic t_win_cfg pick_window();
        case ($urandom_range(9))
            0:       return 7'd1;
            1:       return 7'd64;
            2:       return 7'd0;
            3:       return 7'd127;
            4:       return 7'd65;
            5, 6, 7: return t_win_cfg'($urandom_range(2, 8));
            default: return t_win_cfg'($urandom_range(1, 64));
        endcase
    endfunction

    function automatic t_sample any_sample();
        case ($urandom_range(9))
            0:       return S_MAX;
            1:       return S_MIN;
            2:       return $urandom_range(1) ? 32'sd0 : -32'sd1;
            3, 4, 5: return t_sample'($signed($urandom_range(15)) - 8);
            default: return t_sample'($urandom);
        endcase
    endfunction

    // Random runs. Most begin with a start, some continue across a window
    // change; falling ramps pack the queue, long runs wrap the tags.
    task automatic test_random_streams();
        int      len;
        int      shape;
        int      sent;
        t_sample ramp;
        t_sample s;
        logic    st;
        for (int mode = 0; mode < 3; mode++) begin
            set_idle_mode(mode);
            sent = 0;
            while (sent < RANDOM_PER_MODE) begin
                if ($urandom_range(9) < 4) begin
                    wait_idle();
                    set_window(pick_window());
                end
                len   = ($urandom_range(7) == 0) ? $urandom_range(130, 200)
                                                 : $urandom_range(8, 40);
                if (len > RANDOM_PER_MODE - sent)
                    len = RANDOM_PER_MODE - sent;
                shape = $urandom_range(3);
                ramp  = t_sample'($urandom);
                for (int k = 0; k < len; k++) begin
                    st = (k == 0) ? ($urandom_range(9) < 6) : ($urandom_range(49) == 0);
                    case (shape)
                        1: begin
                            ramp = ramp - t_sample'($urandom_range(3));
                            s    = ramp;
                        end
                        2: begin
                            ramp = ramp + t_sample'($urandom_range(3));
                            s    = ramp;
                        end
                        3:       s = t_sample'($signed($urandom_range(7)) - 4);
                        default: s = any_sample();
                    endcase
                    send_sample(s, st);
                end
                sent += len;
            end
        end
        wait_idle();
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        fail_count = 0;
        set_idle_mode(0);
        i_rst_n            <= 1'b0;
        cfg_ch.valid       <= 1'b0;
        cfg_ch.window_size <= '0;
        smp_ch.valid       <= 1'b0;
        smp_ch.sample      <= '0;
        smp_ch.start_req   <= 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_no_start_after_reset();
        test_signed_extremes();
        test_window_zero();
        test_shrink_and_grow();
        test_random_streams();

        if (fail_count == 0) begin
            $display("sliding_window_maximum_core_tb passed");
        end else begin
            $display("sliding_window_maximum_core_tb failed");
        end
        $finish;
    end

    // Watchdog, far above the slowest legal run.
    initial begin
        #2_000_000;
        $display("sliding_window_maximum_core_tb failed");
        $finish;
    end

endmodule
